@@ hw/rtl/slcf_pkg.sv @@
package slcf_pkg;

    localparam int BYTE_W = 8;
    localparam int CHUNK_BYTES_DEF = 32;
    localparam int SYNC_LEN = 4;
    localparam logic [BYTE_W-1:0] SYNC_CHAR = 8'h32;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

    // Splits a length of 0 to 99 into its decimal tens and ones digits.
    // The nine threshold compares are independent of each other.
    function automatic logic [7:0] dec_split(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] rest;
        tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 7'(10 * k)) begin
                tens = 4'(k);
            end
        end
        rest = v - 7'(tens) * 7'd10;
        return {tens, rest[3:0]};
    endfunction

endpackage

@@ hw/rtl/slcf_if.sv @@
interface slcf_in_if import slcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              message_end;

    modport source (output valid, output data_byte, output message_end, input ready);
    modport sink (input valid, input data_byte, input message_end, output ready);
endinterface

interface slcf_out_if import slcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              run_end;

    modport source (output valid, output out_byte, output frame_end, output run_end,
                    input ready);
    modport sink (input valid, input out_byte, input frame_end, input run_end,
                  output ready);
endinterface

@@ hw/rtl/sync_length_chunk_framer.sv @@
// Channel   Dir  Payload                          Item
// i_in      in   data_byte, message_end           one message byte
// o_out     out  out_byte, frame_end, run_end     one framed byte
//
// A byte that neither fills the chunk nor ends its message leaves the input ready.
// A byte that closes a chunk is taken and then holds the input off until the
// output register has taken each framed byte: 4 sync, 1 or 2 length digits,
// len payload, plus 5 more when the empty trailer frame follows.
// Reset is synchronous and active low; the chunk store itself is not cleared.
// A stalled output simply holds the sequencer; nothing is dropped.
module sync_length_chunk_framer import slcf_pkg::*; #(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slcf_in_if.sink      i_in,
    slcf_out_if.source   o_out
);

    localparam int IDX_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int CNT_W = $clog2(CHUNK_BYTES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CHUNK_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [1:0] SYNC_LAST = 2'(SYNC_LEN - 1);

    typedef enum logic [2:0] {S_IDLE, S_SYNC, S_DHI, S_DLO, S_PAY} t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_earlier, n_earlier;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [3:0]        r_tens, n_tens;
    logic [3:0]        r_ones, n_ones;
    logic              r_extra, n_extra;
    logic              r_empty, n_empty;
    logic [1:0]        r_pos, n_pos;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_ov, n_ov;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_ofe, n_ofe;
    logic              r_ore, n_ore;

    logic              in_acc;
    logic              out_load;
    logic              closes;
    logic              pay_last;
    logic [CNT_W-1:0]  len_nxt;
    logic [BYTE_W-1:0] rd_data;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_load   = !r_ov || o_out.ready;
    assign len_nxt    = r_count + CNT_ONE;
    assign closes     = i_in.message_end || (r_count == LAST_CNT);
    assign pay_last   = (CNT_W'(r_idx) == (r_len - CNT_ONE));

    // The read address follows the next index, so the registered read data
    // always belongs to the current index, even across output stalls.
    slcf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CHUNK_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (i_in.data_byte),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_earlier = r_earlier;
        n_len     = r_len;
        n_tens    = r_tens;
        n_ones    = r_ones;
        n_extra   = r_extra;
        n_empty   = r_empty;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_ov      = r_ov && !o_out.ready;
        n_obyte   = r_obyte;
        n_ofe     = r_ofe;
        n_ore     = r_ore;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (closes) begin
                        // This byte completes a frame: latch its length and digits.
                        n_state          = S_SYNC;
                        n_pos            = 2'd0;
                        n_idx            = '0;
                        n_len            = len_nxt;
                        {n_tens, n_ones} = dec_split(7'(len_nxt));
                        n_extra          = i_in.message_end && (r_count == LAST_CNT)
                                           && r_earlier;
                        n_empty          = 1'b0;
                        n_count          = '0;
                        n_earlier        = !i_in.message_end;
                    end else begin
                        n_count = len_nxt;
                    end
                end
            end
            S_SYNC: begin
                if (out_load) begin
                    n_ov    = 1'b1;
                    n_obyte = SYNC_CHAR;
                    n_ofe   = 1'b0;
                    n_ore   = 1'b0;
                    n_pos   = r_pos + 2'd1;
                    if (r_pos == SYNC_LAST) begin
                        n_state = (!r_empty && (r_tens != 4'd0)) ? S_DHI : S_DLO;
                    end
                end
            end
            S_DHI: begin
                if (out_load) begin
                    n_ov    = 1'b1;
                    n_obyte = ASCII_ZERO + {4'd0, r_tens};
                    n_ofe   = 1'b0;
                    n_ore   = 1'b0;
                    n_state = S_DLO;
                end
            end
            S_DLO: begin
                if (out_load) begin
                    n_ov    = 1'b1;
                    n_obyte = ASCII_ZERO + {4'd0, (r_empty ? 4'd0 : r_ones)};
                    // The empty trailer frame ends on its length digit.
                    n_ofe   = r_empty;
                    n_ore   = r_empty;
                    n_idx   = '0;
                    n_state = r_empty ? S_IDLE : S_PAY;
                    n_empty = 1'b0;
                end
            end
            S_PAY: begin
                if (out_load) begin
                    n_ov    = 1'b1;
                    n_obyte = rd_data;
                    n_ofe   = pay_last;
                    n_ore   = pay_last && !r_extra;
                    if (pay_last) begin
                        if (r_extra) begin
                            n_state = S_SYNC;
                            n_empty = 1'b1;
                            n_extra = 1'b0;
                            n_pos   = 2'd0;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_earlier <= 1'b0;
            r_extra   <= 1'b0;
            r_empty   <= 1'b0;
            r_pos     <= 2'd0;
            r_idx     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_earlier <= n_earlier;
            r_extra   <= n_extra;
            r_empty   <= n_empty;
            r_pos     <= n_pos;
            r_idx     <= n_idx;
            r_ov      <= n_ov;
        end
        r_len   <= n_len;
        r_tens  <= n_tens;
        r_ones  <= n_ones;
        r_obyte <= n_obyte;
        r_ofe   <= n_ofe;
        r_ore   <= n_ore;
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_byte  = r_obyte;
    assign o_out.frame_end = r_ofe;
    assign o_out.run_end   = r_ore;

    a_close_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.message_end) |=> (r_state == S_SYNC))
        else $error("message end did not start a frame");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_CNT)
        else $error("chunk count beyond the last slot");

    a_run_end_on_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.run_end) |-> o_out.frame_end)
        else $error("run end without frame end");

    a_trailer_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extra |-> !r_empty)
        else $error("trailer pending while trailer is being sent");

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_count == '0))
        else $error("open chunk holds bytes while a frame is sent");

endmodule

@@ hw/rtl/slcf_ram.sv @@
module slcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

// Bench for the length-prefixed sync framer.
//
// Message bytes go in on the input channel. Every accepted item is also fed to a
// behavioral copy of the framer inside this module. That copy keeps its own chunk
// buffer, fill count and "already framed" flag. It appends the framed bytes that
// the item should cause to a queue. The output monitor pops that queue once per
// accepted output item and compares every field.
//
// Stimulus comes in three parts:
//   1. A short directed table. It holds single-byte messages with extreme values,
//      a one-digit length and a two-digit length. Where the outcome is obvious,
//      the expected result count and the final payload byte are typed into the row.
//   2. Forced messages for the chunk boundary cases. One is a message that is
//      exactly one full chunk. One is two chunks with the empty trailer frame,
//      sent while the receiver holds off. One is a full chunk followed by a
//      partial one.
//   3. Random messages until the byte budget is used up.
module tb_top;
    import slcf_pkg::*;

    localparam int CHUNK       = CHUNK_BYTES_DEF;
    localparam int ITEMS_TOTAL = 380;
    localparam int RX_HOLD     = 400;     // long receiver hold-off, in cycles
    localparam int TAIL_WAIT   = 64;      // settle time after the last frame
    localparam int CYCLE_LIMIT = 400000;

    // One framed byte as it leaves the block.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              frame_end;
        logic              run_end;
    } framed_t;

    // A row of the directed table. When typed is set, the row also states how many
    // framed bytes the item must cause and what the last of them must be.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              message_end;
        logic              typed;
        logic [5:0]        exp_count;
        logic [BYTE_W-1:0] exp_tail;
    } stim_row_t;

    // One record per item that causes output. The monitor pops one per run_end and,
    // for a typed row, checks the length and last byte of that burst.
    typedef struct {
        int                count;
        logic [BYTE_W-1:0] tail;
        bit                typed;
    } burst_rec_t;

    localparam stim_row_t DIRECTED [0:20] = '{
        // Single-byte messages carrying the payload extremes.
        '{8'h00, 1'b1, 1'b1, 6'd6,  8'h00},
        '{8'hFF, 1'b1, 1'b1, 6'd6,  8'hFF},
        // A nine-byte message: the largest length written with one digit.
        '{8'h01, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h02, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h04, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h08, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h10, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h20, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h40, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h80, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h55, 1'b1, 1'b1, 6'd14, 8'h55},
        // A ten-byte message: the smallest length written with two digits.
        '{8'hFE, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'hFD, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'hFB, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'hF7, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'hEF, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'hDF, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'hBF, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h7F, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'h00, 1'b0, 1'b0, 6'd0,  8'h00},
        '{8'hAA, 1'b1, 1'b1, 6'd16, 8'hAA}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    slcf_in_if  in_ch ();
    slcf_out_if out_ch ();

    sync_length_chunk_framer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Framed bytes still owed by the block, oldest first.
    framed_t    framed_q[$];
    burst_rec_t burst_q[$];

    // State of the behavioral framer.
    logic [BYTE_W-1:0] chunk_buf [CHUNK];
    int                chunk_fill;
    bit                chunk_framed;

    int  mismatches    = 0;
    int  bytes_sent    = 0;
    int  messages_sent = 0;
    int  bytes_checked = 0;
    int  frames_seen   = 0;
    int  trailer_count = 0;
    int  cycle_cnt     = 0;
    int  hold_token    = 0;    // bumped by the sender to ask for a long hold-off
    bit  tx_steady     = 1'b0;

    // Every mismatch counts. Only the first ten are printed in detail.
    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // Idle length for either side: mostly none, often short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Appends one frame of the given length: four sync characters, the length in
    // ASCII decimal, then the payload held in the chunk buffer. frame_end marks the
    // last payload byte, or the length digit itself when the frame is empty.
    function automatic void append_frame(input int len);
        for (int i = 0; i < SYNC_LEN; i++) begin
            framed_q.push_back('{SYNC_CHAR, 1'b0, 1'b0});
        end
        if (len >= 10) begin
            framed_q.push_back('{ASCII_ZERO + 8'(len / 10), 1'b0, 1'b0});
            framed_q.push_back('{ASCII_ZERO + 8'(len % 10), 1'b0, 1'b0});
        end else begin
            framed_q.push_back('{ASCII_ZERO + 8'(len), 1'(len == 0), 1'b0});
        end
        for (int i = 0; i < len; i++) begin
            framed_q.push_back('{chunk_buf[i], 1'(i == len - 1), 1'b0});
        end
    endfunction

    // Advances the behavioral framer by one accepted byte. It returns the number
    // of framed bytes that this byte causes.
    function automatic int framer_step(input logic [BYTE_W-1:0] b, input logic last);
        int      q_start;
        int      n;
        bit      full;
        framed_t tail;
        q_start = framed_q.size();
        if (chunk_fill < CHUNK) begin
            chunk_buf[chunk_fill] = b;
            chunk_fill++;
        end
        if (last) begin
            full = (chunk_fill >= CHUNK);
            append_frame(chunk_fill);
            // A message of several chunks that ends exactly on a chunk boundary
            // closes with an empty frame.
            if (full && chunk_framed) begin
                append_frame(0);
                trailer_count++;
            end
            chunk_fill   = 0;
            chunk_framed = 1'b0;
        end else if (chunk_fill >= CHUNK) begin
            // The chunk filled in the middle of a message, so it is framed now.
            append_frame(chunk_fill);
            chunk_fill   = 0;
            chunk_framed = 1'b1;
        end
        n = framed_q.size() - q_start;
        if (n > 0) begin
            tail = framed_q.pop_back();
            tail.run_end = 1'b1;
            framed_q.push_back(tail);
        end
        return n;
    endfunction

    // Offers one byte and waits until it is taken. The task is entered at a
    // falling edge and returns at the falling edge after the acceptance. The valid
    // stays high when it returns, so back-to-back items need no extra assignment.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                             input logic typed, input int exp_count,
                             input logic [BYTE_W-1:0] exp_tail);
        int gap;
        int n;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.data_byte   = b;
        in_ch.message_end = last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        n = framer_step(b, last);
        if (n > 0) begin
            burst_q.push_back('{typed ? exp_count : n, exp_tail, typed});
        end
        bytes_sent++;
        if (last) begin
            messages_sent++;
        end
        @(negedge i_clk);
    endtask

    // Sends a message of random bytes. Some messages are sent with no gaps at all.
    task automatic send_message(input int len);
        tx_steady = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), 1'(i == len - 1), 1'b0, 0, 8'h00);
        end
    endtask

    // Stops offering and waits until the block has delivered everything it owes.
    task automatic drain_output();
        in_ch.valid = 1'b0;
        while (framed_q.size() != 0) @(negedge i_clk);
    endtask

    // Random message length. Most lengths are short. Chunk multiples and lengths
    // just past a chunk are weighted up so that the boundary cases come up often.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return $urandom_range(1, 9);
        end else if (r < 70) begin
            return $urandom_range(10, CHUNK - 1);
        end else if (r < 80) begin
            return CHUNK;
        end else if (r < 86) begin
            return 2 * CHUNK;
        end
        return $urandom_range(CHUNK + 1, 2 * CHUNK + 6);
    endfunction

    // Output side. The ready is driven at the falling edge and the output is
    // sampled at the rising edge. The receiver idles at random and has stretches
    // with no idling. When the sender asks, it holds off without a break for the
    // RX_HOLD hold-off so that the block fills up and stops taking input.
    initial begin : rx_side
        int         gap_left;
        int         hold_left;
        int         token_seen;
        int         burst_len;
        bit         rx_steady;
        framed_t    got;
        framed_t    want;
        burst_rec_t rec;
        gap_left     = 0;
        hold_left    = 0;
        token_seen   = 0;
        burst_len    = 0;
        rx_steady    = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_token != token_seen) begin
                token_seen = hold_token;
                hold_left  = RX_HOLD;
            end
            if ($urandom_range(0, 149) == 0) begin
                rx_steady = !rx_steady;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (gap_left > 0) begin
                out_ch.ready = 1'b0;
                gap_left--;
            end else begin
                out_ch.ready = 1'b1;
                gap_left     = rx_steady ? 0 : pick_gap();
            end

            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = '{out_ch.out_byte, out_ch.frame_end, out_ch.run_end};
                bytes_checked++;
                burst_len++;
                if (got.frame_end === 1'b1) begin
                    frames_seen++;
                end
                if (framed_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected framed byte: out_byte=%h frame_end=%b run_end=%b",
                        got.out_byte, got.frame_end, got.run_end));
                end else begin
                    want = framed_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end
                            || got.run_end !== want.run_end) begin
                        report_mismatch($sformatf(
                            "framed byte %0d: expected %h/%b/%b, got %h/%b/%b",
                            bytes_checked, want.out_byte, want.frame_end, want.run_end,
                            got.out_byte, got.frame_end, got.run_end));
                    end
                end
                // A run_end closes the burst caused by one input item. For a typed
                // directed row, its length and last byte are also checked against
                // the table.
                if (got.run_end === 1'b1) begin
                    if (burst_q.size() == 0) begin
                        report_mismatch("run_end with no burst outstanding");
                    end else begin
                        rec = burst_q.pop_front();
                        if (rec.typed && (burst_len != rec.count
                                || got.out_byte !== rec.tail)) begin
                            report_mismatch($sformatf(
                                "burst: expected %0d bytes ending %h, got %0d ending %h",
                                rec.count, rec.tail, burst_len, got.out_byte));
                        end
                    end
                    burst_len = 0;
                end
            end
        end
    end

    // The run is stopped if it has not finished within the cycle budget.
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk) cycle_cnt++;
        $display("tb_top: FAIL");
        $finish;
    end

    // Input side and the overall sequence of the run.
    initial begin : tx_side
        int len;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.message_end = 1'b0;
        chunk_fill        = 0;
        chunk_framed      = 1'b0;
        i_rst_n           = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table.
        foreach (DIRECTED[i]) begin
            send_byte(DIRECTED[i].data_byte, DIRECTED[i].message_end, DIRECTED[i].typed,
                      int'(DIRECTED[i].exp_count), DIRECTED[i].exp_tail);
        end
        drain_output();

        // A message of exactly one chunk. It gives a single full frame and no
        // trailer.
        send_message(CHUNK);
        // A two-chunk message sent while the receiver holds off. The first chunk
        // backs up in the block, and the block must stop taking bytes until the
        // receiver drains the frame. The message then ends with the empty trailer.
        hold_token++;
        send_message(2 * CHUNK);
        drain_output();
        // A full chunk framed in the middle of a message, then a short remainder.
        send_message(CHUNK + 8);

        // Random messages until the byte budget is used up.
        while (bytes_sent < ITEMS_TOTAL) begin
            len = pick_length();
            send_message(len);
        end
        drain_output();
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (burst_q.size() != 0) begin
            report_mismatch($sformatf("%0d result bursts never arrived", burst_q.size()));
        end

        $display("tb_top: %0d bytes in %0d messages, %0d framed bytes checked",
                 bytes_sent, messages_sent, bytes_checked);
        $display("tb_top: %0d frames closed, %0d empty trailers, %0d mismatches",
                 frames_seen, trailer_count, mismatches);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

@@ sync_length_chunk_framer.f @@
hw/rtl/slcf_pkg.sv
hw/rtl/slcf_if.sv
hw/rtl/slcf_ram.sv
hw/rtl/sync_length_chunk_framer.sv
bench/tb_top.sv
